// ===== design/gssg_pkg.sv =====
// ----------------------------------------------------------------------------
// gssg_pkg
// Constants, register indexes and carried types of the gaussian smoothing
// gain pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gssg_pkg;

  localparam int NS = 15;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 3'd6;

  localparam logic [10:0] GRID_RESET  = 11'd256;
  localparam logic [31:0] ONE_Q31     = 32'h8000_0000;
  localparam logic [47:0] ONE_Q47     = 48'h8000_0000_0000;
  localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;
  localparam logic [30:0] LN2_Q31     = 31'd1488522236;
  localparam logic [31:0] RECIP3      = 32'hAAAA_AAAB;
  localparam logic [53:0] EXP_LIMIT   = 54'd23 << 25;
  localparam logic [80:0] ROUND_HALF  = 81'd1 << 46;

  // 2^(-i/8) in Q1.31
  localparam logic [31:0] POW2_FRAC [8] = '{
    32'd2147483648, 32'd1969251188, 32'd1805811301, 32'd1655936265,
    32'd1518500250, 32'd1392470869, 32'd1276901417, 32'd1170923762
  };

  typedef struct packed {
    logic [31:0] mag_re;
    logic [31:0] mag_im;
    logic        neg_re;
    logic        neg_im;
  } bin_t;

  typedef struct packed {
    logic       zero;
    logic [5:0] sh;
    logic [2:0] idx;
  } xinfo_t;

endpackage

`default_nettype wire

// ===== design/gaussian_spectral_smoothing_gain.sv =====
// ----------------------------------------------------------------------------
// gaussian_spectral_smoothing_gain
// Gaussian low-pass gain applied to one complex 3D spectral bin per beat.
// ----------------------------------------------------------------------------
// One beat in gives one beat out, and a new beat is taken in every cycle
// unless the output is stalled with every stage full. The work runs through
// a 15-stage pipeline (fold and square, width product, exponent sum, log2(e)
// scale, three polynomial powers, divide by six, polynomial sum, table
// product, shift, scale product, gain clamp, bin product, rounding); the last
// stage is the output register. Each stage holds its beat when it and every
// stage after it are full and the output is stalled, so a stalled output
// only blocks input once every stage holds a beat. The user must write the
// configuration through cfg_we/cfg_index/cfg_data while idle (not enforced).
`default_nettype none

module gaussian_spectral_smoothing_gain
  import gssg_pkg::*;
#(
  parameter int MAX_GRID = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // freq_x[9:0], freq_y[19:10], freq_z[29:20], bin_re[61:30], bin_im[93:62]
  input  wire logic [95:0]           s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // out_re[31:0], out_im[63:32]
  output logic [63:0]                m_axis_tdata
);

  localparam int NW = (MAX_GRID >= 2047) ? 11 : $clog2(MAX_GRID + 1);
  localparam logic [NW-1:0] GRID_LIM = NW'((MAX_GRID > 2047) ? 2047 : MAX_GRID);

  // configuration
  logic [10:0] grid_x, grid_y, grid_z;
  logic [31:0] width_x, width_y, width_z;
  logic [47:0] scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_x  <= GRID_RESET;
      grid_y  <= GRID_RESET;
      grid_z  <= GRID_RESET;
      width_x <= '0;
      width_y <= '0;
      width_z <= '0;
      scale   <= ONE_Q47;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_X:  grid_x  <= cfg_data[10:0];
        REG_GRID_Y:  grid_y  <= cfg_data[10:0];
        REG_GRID_Z:  grid_z  <= cfg_data[10:0];
        REG_WIDTH_X: width_x <= cfg_data[31:0];
        REG_WIDTH_Y: width_y <= cfg_data[31:0];
        REG_WIDTH_Z: width_z <= cfg_data[31:0];
        REG_SCALE:   scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valids and per-stage advance
  logic [NS:1] v;
  logic [NS:1] en;

  for (genvar gi = 1; gi <= NS; gi++) begin : g_en
    assign en[gi] = m_axis_tready | ~(&v[NS:gi]);
  end

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = v[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= s_axis_tvalid;
      for (int i = 2; i <= NS; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // folded index magnitude, always below 1024
  function automatic logic [9:0] fold_mag(input logic [9:0] k, input logic [10:0] n);
    logic [NW-1:0]     nn;
    logic signed [11:0] d;
    logic [9:0]        m;
    nn = (n > 11'(GRID_LIM)) ? GRID_LIM : n[NW-1:0];
    d  = $signed({2'b00, k}) - $signed(12'(nn));
    if ({1'b0, k, 1'b0} > 12'(nn)) begin
      m = d[11] ? 10'(-d) : 10'(d);
    end else begin
      m = k;
    end
    return m;
  endfunction

  // stage 1: fold, square, bin magnitudes
  logic [9:0]  mag_x, mag_y, mag_z;
  logic [31:0] raw_re, raw_im;
  logic [19:0] sq1_x, sq1_y, sq1_z;
  bin_t        bin_q [1:NS-1];

  assign mag_x  = fold_mag(s_axis_tdata[9:0], grid_x);
  assign mag_y  = fold_mag(s_axis_tdata[19:10], grid_y);
  assign mag_z  = fold_mag(s_axis_tdata[29:20], grid_z);
  assign raw_re = s_axis_tdata[61:30];
  assign raw_im = s_axis_tdata[93:62];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sq1_x <= mag_x * mag_x;
      sq1_y <= mag_y * mag_y;
      sq1_z <= mag_z * mag_z;
      bin_q[1].neg_re <= raw_re[31];
      bin_q[1].neg_im <= raw_im[31];
      bin_q[1].mag_re <= raw_re[31] ? 32'd0 - raw_re : raw_re;
      bin_q[1].mag_im <= raw_im[31] ? 32'd0 - raw_im : raw_im;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 2; i <= NS - 1; i++) begin
      if (en[i]) bin_q[i] <= bin_q[i-1];
    end
  end

  // stage 2: per-axis k^2 * c
  logic [51:0] term2_x, term2_y, term2_z;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      term2_x <= sq1_x * width_x;
      term2_y <= sq1_y * width_y;
      term2_z <= sq1_z * width_z;
    end
  end

  // stage 3: exponent sum and underflow check
  logic [53:0] t_sum;
  logic [29:0] t3;
  logic        zero3;

  assign t_sum = 54'(term2_x) + 54'(term2_y) + 54'(term2_z);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      t3    <= t_sum[29:0];
      zero3 <= (t_sum >= EXP_LIMIT);
    end
  end

  // stage 4: y = t * log2(e), split into shift, table index, fraction
  logic [60:0] y_prod;
  logic [30:0] r4;
  xinfo_t      xi [4:10];

  assign y_prod = t3 * LOG2E_Q30;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      r4         <= y_prod[51:21];
      xi[4].zero <= zero3;
      xi[4].sh   <= y_prod[60:55];
      xi[4].idx  <= y_prod[54:52];
    end
    for (int i = 5; i <= 10; i++) begin
      if (en[i]) xi[i] <= xi[i-1];
    end
  end

  // stages 5..8: u = r*ln2, u^2, u^3, u^3/6
  logic [61:0] u_prod, u2_prod, u3_prod, q_prod;
  logic [30:0] u5, u6, u7, u8;
  logic [30:0] u2_6, u2_7, u2_8;
  logic [30:0] u3_7;
  logic [28:0] q8;

  assign u_prod  = r4 * LN2_Q31;
  assign u2_prod = u5 * u5;
  assign u3_prod = u2_6 * u6;
  assign q_prod  = u3_7[30:1] * RECIP3;

  always_ff @(posedge clk) begin
    if (en[5]) u5 <= u_prod[61:31];
    if (en[6]) begin
      u6   <= u5;
      u2_6 <= u2_prod[61:31];
    end
    if (en[7]) begin
      u7   <= u6;
      u2_7 <= u2_6;
      u3_7 <= u3_prod[61:31];
    end
    if (en[8]) begin
      u8   <= u7;
      u2_8 <= u2_7;
      q8   <= q_prod[61:33];
    end
  end

  // stage 9: polynomial for 2^(-frac) and table entry
  logic [33:0] p_sum;
  logic [31:0] p9, tab9;

  assign p_sum = 34'(ONE_Q31) + 34'(u2_8[30:1]) - 34'(u8) - 34'(q8);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      p9   <= p_sum[31:0];
      tab9 <= POW2_FRAC[xi[8].idx];
    end
  end

  // stage 10: mantissa
  logic [63:0] m_prod;
  logic [31:0] m10;

  assign m_prod = tab9 * p9;

  always_ff @(posedge clk) begin
    if (en[10]) m10 <= m_prod[62:31];
  end

  // stage 11: integer part of the exponent as a right shift
  logic [31:0] e11;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      if (xi[10].zero || xi[10].sh[5]) begin
        e11 <= '0;
      end else begin
        e11 <= m10 >> xi[10].sh[4:0];
      end
    end
  end

  // stage 12: scale * e, in two halves
  logic [55:0] sg_hi12, sg_lo12;

  always_ff @(posedge clk) begin
    if (en[12]) begin
      sg_hi12 <= scale[47:24] * e11;
      sg_lo12 <= scale[23:0] * e11;
    end
  end

  // stage 13: gain, clamped to one
  logic [80:0] g_sum;
  logic [49:0] g_full;
  logic [47:0] g13;

  assign g_sum  = 81'({sg_hi12, 24'd0}) + 81'(sg_lo12);
  assign g_full = g_sum[80:31];

  always_ff @(posedge clk) begin
    if (en[13]) g13 <= (g_full > 50'(ONE_Q47)) ? ONE_Q47 : g_full[47:0];
  end

  // stage 14: bin * gain, in two halves per part
  logic [55:0] re_hi14, re_lo14, im_hi14, im_lo14;

  always_ff @(posedge clk) begin
    if (en[14]) begin
      re_hi14 <= bin_q[13].mag_re * g13[47:24];
      re_lo14 <= bin_q[13].mag_re * g13[23:0];
      im_hi14 <= bin_q[13].mag_im * g13[47:24];
      im_lo14 <= bin_q[13].mag_im * g13[23:0];
    end
  end

  // stage 15: round to nearest, restore sign, output register
  logic [80:0] re_sum, im_sum;
  logic [31:0] re_mag, im_mag;

  assign re_sum = 81'({re_hi14, 24'd0}) + 81'(re_lo14) + ROUND_HALF;
  assign im_sum = 81'({im_hi14, 24'd0}) + 81'(im_lo14) + ROUND_HALF;
  assign re_mag = re_sum[78:47];
  assign im_mag = im_sum[78:47];

  always_ff @(posedge clk) begin
    if (en[15]) begin
      m_axis_tdata[31:0]  <= bin_q[14].neg_re ? 32'd0 - re_mag : re_mag;
      m_axis_tdata[63:32] <= bin_q[14].neg_im ? 32'd0 - im_mag : im_mag;
    end
  end

  // checks
  a_ready_when_room: assert property (@(posedge clk) disable iff (rst)
    !(&v) |-> s_axis_tready)
    else $error("input stalled while pipeline has room");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v[8] && !en[8] |=> v[8] && $stable(q8))
    else $error("stage 8 beat changed while stalled");

  // the cubic reaches about 0.49 at the top of the fraction range
  a_poly_range: assert property (@(posedge clk) disable iff (rst)
    v[9] |-> p9 <= ONE_Q31 && p9 > (ONE_Q31 >> 2))
    else $error("exp polynomial out of range");

  a_mant_range: assert property (@(posedge clk) disable iff (rst)
    v[10] |-> m10 <= ONE_Q31)
    else $error("exp mantissa above one");

endmodule

`default_nettype wire
